>>> src/htsd_pkg.sv
package htsd_pkg;

   localparam int TREE_NODES_DEFAULT  = 257;
   localparam int COUNT_WIDTH_DEFAULT = 24;
   localparam int LIMIT_WIDTH         = 24;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 24'hFF_FFFF;
   localparam logic [15:0]            END_VALUE   = 16'd256;
   localparam logic [31:0]            EMPTY_NODE  = 32'hFEFF_FEFF;

   // result kinds
   localparam logic [1:0] KIND_SYMBOL = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // outcome of one tree step
   localparam logic [1:0] STEP_LINK  = 2'd0;
   localparam logic [1:0] STEP_SYM   = 2'd1;
   localparam logic [1:0] STEP_END   = 2'd2;
   localparam logic [1:0] STEP_ERROR = 2'd3;

   typedef struct packed {
      logic       restart;
      logic       hold_byte;
      logic       set_count;
      logic       load_node;
      logic       walk_reset;
      logic       start_walk;
      logic       walk_step;
      logic       push;
      logic [1:0] push_kind;
      logic       seal;
   } cmd_type;

   typedef struct packed {
      logic       count_bad;
      logic       count_zero;
      logic       load_done;
      logic       limit_zero;
      logic       limit_reached;
      logic [1:0] step_kind;
      logic       bit_last;
      logic       sym_limit;
      logic       last_flag;
      logic       pend_valid;
      logic       push_ok;
      logic       out_free;
   } status_type;

endpackage

>>> src/htsd_ram.sv
module htsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 257
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/htsd_ctrl.sv
module htsd_ctrl import htsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   input  logic       req_tlast,
   input  status_type status,
   output logic       req_tready,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_CNT_LO = 4'd0;
   localparam logic [3:0] ST_CNT_HI = 4'd1;
   localparam logic [3:0] ST_NODES  = 4'd2;
   localparam logic [3:0] ST_DATA   = 4'd3;
   localparam logic [3:0] ST_DONE   = 4'd4;
   localparam logic [3:0] ST_WALK   = 4'd5;
   localparam logic [3:0] ST_LIMIT  = 4'd6;
   localparam logic [3:0] ST_TAIL   = 4'd7;
   localparam logic [3:0] ST_SEAL   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic [3:0] phase;
   logic       accept;

   assign req_tready = (state_ff == ST_CNT_LO) || (state_ff == ST_CNT_HI) ||
                       (state_ff == ST_NODES) || (state_ff == ST_DATA) ||
                       (state_ff == ST_DONE);
   assign accept = req_tvalid && req_tready;
   assign phase  = req_tuser ? ST_CNT_LO : state_ff;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CNT_LO, ST_CNT_HI, ST_NODES, ST_DATA, ST_DONE: begin
            if (accept) begin
               cmd.restart = req_tuser;
               case (phase)
                  ST_CNT_LO: begin
                     cmd.hold_byte = 1'b1;
                     if (req_tlast) begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = KIND_ERROR;
                        ret_in        = ST_DONE;
                        state_in      = ST_SEAL;
                     end else begin
                        state_in = ST_CNT_HI;
                     end
                  end
                  ST_CNT_HI: begin
                     if (status.count_bad) begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = KIND_ERROR;
                        ret_in        = ST_DONE;
                        state_in      = ST_SEAL;
                     end else begin
                        cmd.set_count = 1'b1;
                        if (status.count_zero) begin
                           cmd.walk_reset = 1'b1;
                           if (status.limit_zero || req_tlast) begin
                              cmd.push      = 1'b1;
                              cmd.push_kind = KIND_END;
                              ret_in        = ST_DONE;
                              state_in      = ST_SEAL;
                           end else begin
                              state_in = ST_DATA;
                           end
                        end else if (req_tlast) begin
                           cmd.push      = 1'b1;
                           cmd.push_kind = KIND_ERROR;
                           ret_in        = ST_DONE;
                           state_in      = ST_SEAL;
                        end else begin
                           state_in = ST_NODES;
                        end
                     end
                  end
                  ST_NODES: begin
                     cmd.load_node = 1'b1;
                     if (status.load_done) begin
                        cmd.walk_reset = 1'b1;
                        if (status.limit_zero || req_tlast) begin
                           cmd.push      = 1'b1;
                           cmd.push_kind = KIND_END;
                           ret_in        = ST_DONE;
                           state_in      = ST_SEAL;
                        end else begin
                           state_in = ST_DATA;
                        end
                     end else if (req_tlast) begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = KIND_ERROR;
                        ret_in        = ST_DONE;
                        state_in      = ST_SEAL;
                     end
                  end
                  ST_DATA: begin
                     if (status.limit_reached) begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = KIND_END;
                        ret_in        = ST_DONE;
                        state_in      = ST_SEAL;
                     end else begin
                        cmd.start_walk = 1'b1;
                        state_in       = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            unique case (status.step_kind)
               STEP_LINK: begin
                  cmd.walk_step = 1'b1;
                  if (status.bit_last) begin
                     state_in = ST_TAIL;
                  end
               end
               STEP_SYM: begin
                  if (status.push_ok) begin
                     cmd.push      = 1'b1;
                     cmd.push_kind = KIND_SYMBOL;
                     cmd.walk_step = 1'b1;
                     if (status.sym_limit) begin
                        state_in = ST_LIMIT;
                     end else if (status.bit_last) begin
                        state_in = ST_TAIL;
                     end
                  end
               end
               STEP_END: begin
                  if (status.push_ok) begin
                     cmd.push      = 1'b1;
                     cmd.push_kind = KIND_END;
                     ret_in        = ST_DONE;
                     state_in      = ST_SEAL;
                  end
               end
               STEP_ERROR: begin
                  if (status.push_ok) begin
                     cmd.push      = 1'b1;
                     cmd.push_kind = KIND_ERROR;
                     ret_in        = ST_DONE;
                     state_in      = ST_SEAL;
                  end
               end
            endcase
         end
         ST_LIMIT: begin
            if (status.push_ok) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_END;
               ret_in        = ST_DONE;
               state_in      = ST_SEAL;
            end
         end
         ST_TAIL: begin
            if (status.last_flag) begin
               if (status.push_ok) begin
                  cmd.push      = 1'b1;
                  cmd.push_kind = KIND_END;
                  ret_in        = ST_DONE;
                  state_in      = ST_SEAL;
               end
            end else if (status.pend_valid) begin
               ret_in   = ST_DATA;
               state_in = ST_SEAL;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_SEAL: begin
            if (status.out_free) begin
               cmd.seal = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_CNT_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CNT_LO;
         ret_ff   <= ST_CNT_LO;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

>>> src/htsd_datapath.sv
module htsd_datapath import htsd_pkg::*; #(
   parameter int TREE_NODES  = TREE_NODES_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_byte,
   input  logic                   req_last,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_valid,
   input  logic [LIMIT_WIDTH-1:0] csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_symbol,
   output logic [1:0]             rsp_kind,
   output logic [COUNT_WIDTH-1:0] rsp_count,
   output logic                   rsp_end
);

   localparam int NW   = $clog2(TREE_NODES);
   localparam int LPW  = NW + 2;
   localparam int CMPW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [7:0]             held_ff, held_in;
   logic [NW-1:0]          total_ff, total_in;
   logic [LPW-1:0]         lp_ff, lp_in;
   logic [23:0]            asm_ff, asm_in;
   logic [NW-1:0]          walk_ff, walk_in;
   logic [COUNT_WIDTH-1:0] emitted_ff, emitted_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic [2:0]             bit_ff, bit_in;

   logic                   pend_valid_ff, pend_valid_in;
   logic [7:0]             pend_symbol_ff, pend_symbol_in;
   logic [1:0]             pend_kind_ff, pend_kind_in;
   logic [COUNT_WIDTH-1:0] pend_count_ff, pend_count_in;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_symbol_ff, out_symbol_in;
   logic [1:0]             out_kind_ff, out_kind_in;
   logic [COUNT_WIDTH-1:0] out_count_ff, out_count_in;
   logic                   out_end_ff, out_end_in;

   logic [15:0]            cnt16;
   logic [LPW-1:0]         lp_next;
   logic [15:0]            size16;
   logic [31:0]            entry;
   logic                   cur_bit;
   logic [15:0]            link;
   logic [15:0]            value;
   logic [1:0]             step_kind;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   out_free;
   logic                   push_ok;
   logic [7:0]             push_symbol;
   logic [COUNT_WIDTH-1:0] push_count;

   logic                   ram_wr_en;
   logic [NW-1:0]          ram_wr_addr;
   logic [31:0]            ram_wr_data;

   assign cnt16     = {req_byte, held_ff};
   assign lp_next   = lp_ff + 1'b1;
   assign size16    = (total_ff == '0) ? 16'd1 : 16'(total_ff);
   assign cur_bit   = byte_ff[bit_ff];
   assign link      = cur_bit ? entry[31:16] : entry[15:0];
   assign value     = ~link;
   assign count_inc = emitted_ff + 1'b1;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign push_ok   = !pend_valid_ff || out_free;

   always_comb begin
      if (!link[15]) begin
         step_kind = (link >= size16) ? STEP_ERROR : STEP_LINK;
      end else if (value == END_VALUE) begin
         step_kind = STEP_END;
      end else if (value > END_VALUE) begin
         step_kind = STEP_ERROR;
      end else begin
         step_kind = STEP_SYM;
      end
   end

   always_comb begin
      status.count_bad     = cnt16 >= 16'(TREE_NODES);
      status.count_zero    = cnt16 == 16'd0;
      status.load_done     = lp_next >= {total_ff, 2'b00};
      status.limit_zero    = limit_ff == '0;
      status.limit_reached = CMPW'(emitted_ff) >= CMPW'(limit_ff);
      status.step_kind     = step_kind;
      status.bit_last      = bit_ff == 3'd7;
      status.sym_limit     = CMPW'(count_inc) >= CMPW'(limit_ff);
      status.last_flag     = last_ff;
      status.pend_valid    = pend_valid_ff;
      status.push_ok       = push_ok;
      status.out_free      = out_free;
   end

   // tree memory: whole node written on its fourth byte, node 0 preset on count
   assign ram_wr_en   = cmd.set_count || (cmd.load_node && (lp_ff[1:0] == 2'd3));
   assign ram_wr_addr = cmd.set_count ? '0 : lp_ff[LPW-1:2];
   assign ram_wr_data = cmd.set_count ? EMPTY_NODE : {req_byte, asm_ff};

   htsd_ram #(
      .WIDTH (32),
      .DEPTH (TREE_NODES)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (walk_in),
      .rd_data (entry)
   );

   always_comb begin
      limit_in   = limit_ff;
      held_in    = held_ff;
      total_in   = total_ff;
      lp_in      = lp_ff;
      asm_in     = asm_ff;
      walk_in    = walk_ff;
      emitted_in = emitted_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      bit_in     = bit_ff;

      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (cmd.hold_byte) begin
         held_in = req_byte;
      end
      if (cmd.set_count) begin
         total_in = cnt16[NW-1:0];
         lp_in    = '0;
      end
      if (cmd.load_node) begin
         lp_in = lp_next;
         unique case (lp_ff[1:0])
            2'd0: asm_in[7:0]   = req_byte;
            2'd1: asm_in[15:8]  = req_byte;
            2'd2: asm_in[23:16] = req_byte;
            2'd3: asm_in        = asm_ff;
         endcase
      end
      if (cmd.start_walk) begin
         byte_in = req_byte;
         last_in = req_last;
         bit_in  = 3'd0;
      end
      if (cmd.walk_step) begin
         bit_in  = bit_ff + 3'd1;
         walk_in = (step_kind == STEP_LINK) ? link[NW-1:0] : '0;
         if (step_kind == STEP_SYM) begin
            emitted_in = count_inc;
         end
      end
      if (cmd.restart) begin
         lp_in      = '0;
         emitted_in = '0;
      end
      if (cmd.restart || cmd.walk_reset) begin
         walk_in = '0;
      end
   end

   // a restarting request reports the cleared count
   assign push_symbol = (cmd.push_kind == KIND_SYMBOL) ? value[7:0] : 8'd0;
   assign push_count  = (cmd.push_kind == KIND_SYMBOL) ? count_inc :
                        (cmd.restart ? '0 : emitted_ff);

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_symbol_in = pend_symbol_ff;
      pend_kind_in   = pend_kind_ff;
      pend_count_in  = pend_count_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_symbol_in  = out_symbol_ff;
      out_kind_in    = out_kind_ff;
      out_count_in   = out_count_ff;
      out_end_in     = out_end_ff;

      if (cmd.push) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_symbol_in = pend_symbol_ff;
            out_kind_in   = pend_kind_ff;
            out_count_in  = pend_count_ff;
            out_end_in    = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_symbol_in = push_symbol;
         pend_kind_in   = cmd.push_kind;
         pend_count_in  = push_count;
      end
      if (cmd.seal) begin
         out_valid_in  = 1'b1;
         out_symbol_in = pend_symbol_ff;
         out_kind_in   = pend_kind_ff;
         out_count_in  = pend_count_ff;
         out_end_in    = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         held_ff       <= '0;
         total_ff      <= '0;
         lp_ff         <= '0;
         walk_ff       <= '0;
         emitted_ff    <= '0;
         bit_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         limit_ff      <= limit_in;
         held_ff       <= held_in;
         total_ff      <= total_in;
         lp_ff         <= lp_in;
         walk_ff       <= walk_in;
         emitted_ff    <= emitted_in;
         bit_ff        <= bit_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff         <= asm_in;
      byte_ff        <= byte_in;
      last_ff        <= last_in;
      pend_symbol_ff <= pend_symbol_in;
      pend_kind_ff   <= pend_kind_in;
      pend_count_ff  <= pend_count_in;
      out_symbol_ff  <= out_symbol_in;
      out_kind_ff    <= out_kind_in;
      out_count_ff   <= out_count_in;
      out_end_ff     <= out_end_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_symbol = out_symbol_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_end    = out_end_ff;

endmodule

>>> src/huffman_tree_stream_decoder_core.sv
// header bytes: taken back to back, but a byte that ends the stream with a result passes the seal state
// data bytes: unless the output limit is reached, the walk steps one bit per cycle while
//   results can be pushed (tree ram read loop); tail state, then seal if the byte has results
// results leave through an output register; a full output stalls the walk
// reset: synchronous, active high; control state cleared, output limit set to
//   all ones; tree ram not cleared, node 0 is preset each time a count is taken
module huffman_tree_stream_decoder_core import htsd_pkg::*; #(
   parameter int  TREE_NODES  = TREE_NODES_DEFAULT,
   parameter int  COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   localparam int RSP_DATA_W  = ((8 + COUNT_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // in_byte
   input  logic                   req_tuser,   // first_byte
   input  logic                   req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // symbol, decoded_count
   output logic [1:0]             rsp_tuser,   // kind
   output logic                   rsp_tlast,   // run_end
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LIMIT_WIDTH-1:0] csr_data     // output_limit
);

   cmd_type                cmd;
   status_type             status;
   logic [7:0]             rsp_symbol;
   logic [COUNT_WIDTH-1:0] rsp_count;

   assign csr_ready = 1'b1;

   htsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   htsd_datapath #(
      .TREE_NODES  (TREE_NODES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_symbol (rsp_symbol),
      .rsp_kind   (rsp_tuser),
      .rsp_count  (rsp_count),
      .rsp_end    (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_count, rsp_symbol});

endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import htsd_pkg::*;

   localparam int TREE_LIMIT    = TREE_NODES_DEFAULT;
   localparam int RSP_W         = ((8 + COUNT_WIDTH_DEFAULT + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 24;

   typedef enum logic [2:0] {
      PARSE_COUNT_LO,
      PARSE_COUNT_HI,
      PARSE_NODES,
      PARSE_DATA,
      PARSE_DONE
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  symbol;
      logic [1:0]  kind;
      logic [23:0] decoded_count;
      logic        run_end;
   } decode_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first_flag;
      logic       last_flag;
   } stream_request_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [LIMIT_WIDTH-1:0] csr_data   = '0;

   // decoder shadow state
   logic [LIMIT_WIDTH-1:0] limit_shadow = LIMIT_RESET;
   parse_state_type        parse_state  = PARSE_COUNT_LO;
   logic [8:0]             node_total   = '0;
   logic [10:0]            load_pos     = '0;
   logic [7:0]             count_low    = '0;
   logic [31:0]            tree_ram [TREE_LIMIT] = '{default: '0};
   logic [8:0]             walk_node    = '0;
   logic [23:0]            emitted      = '0;

   decode_result_type  awaited[$];
   decode_result_type  byte_results[$];
   stream_request_type pending_stream[$];
   logic [31:0]        tree_image [TREE_LIMIT];

   int mismatches         = 0;
   int live_requests      = 0;
   int request_idle_pct   = 0;
   int response_stall_pct = 0;
   int hold_off           = 0;

   huffman_tree_stream_decoder_core dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .req_tlast,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .rsp_tlast,
      .csr_valid,
      .csr_ready,
      .csr_data
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_result(input logic [7:0] sym, input logic [1:0] kind);
      decode_result_type r;
      r.symbol        = sym;
      r.kind          = kind;
      r.decoded_count = emitted;
      r.run_end       = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic void close_stream(input logic [1:0] kind);
      add_result(8'h00, kind);
      parse_state = PARSE_DONE;
   endfunction

   function automatic void begin_data(input logic last_flag);
      parse_state = PARSE_DATA;
      walk_node   = '0;
      if (limit_shadow == 0 || last_flag) close_stream(KIND_END);
   endfunction

   function automatic void decode_request(input stream_request_type rq);
      logic [15:0]       count_word;
      logic [15:0]       link;
      logic [15:0]       leaf;
      logic [31:0]       entry;
      int                tree_size;
      int                i;
      int                idx;
      int                sh;
      decode_result_type r;
      byte_results.delete();
      if (rq.first_flag) begin
         parse_state = PARSE_COUNT_LO;
         walk_node   = '0;
         emitted     = '0;
         load_pos    = '0;
      end
      case (parse_state)
         PARSE_COUNT_LO: begin
            count_low   = rq.data;
            parse_state = PARSE_COUNT_HI;
            if (rq.last_flag) close_stream(KIND_ERROR);
         end
         PARSE_COUNT_HI: begin
            count_word = {rq.data, count_low};
            if (count_word >= TREE_LIMIT) begin
               close_stream(KIND_ERROR);
            end else begin
               node_total  = count_word[8:0];
               load_pos    = '0;
               tree_ram[0] = EMPTY_NODE;
               if (count_word == 0) begin_data(rq.last_flag);
               else if (rq.last_flag) close_stream(KIND_ERROR);
               else parse_state = PARSE_NODES;
            end
         end
         PARSE_NODES: begin
            idx = int'(load_pos[10:2]);
            sh  = 8 * int'(load_pos[1:0]);
            tree_ram[idx][sh +: 8] = rq.data;
            load_pos = load_pos + 11'd1;
            if (int'(load_pos) >= 4 * int'(node_total)) begin_data(rq.last_flag);
            else if (rq.last_flag) close_stream(KIND_ERROR);
         end
         PARSE_DATA: begin
            if (emitted >= limit_shadow) begin
               close_stream(KIND_END);
            end else begin
               tree_size = (node_total != 0) ? int'(node_total) : 1;
               for (i = 0; i < 8 && parse_state == PARSE_DATA; i++) begin
                  entry = tree_ram[walk_node];
                  link  = rq.data[i] ? entry[31:16] : entry[15:0];
                  if (!link[15]) begin
                     if (int'(link) >= tree_size) close_stream(KIND_ERROR);
                     else walk_node = link[8:0];
                  end else begin
                     leaf = ~link;
                     if (leaf == END_VALUE) begin
                        close_stream(KIND_END);
                     end else if (leaf > END_VALUE) begin
                        close_stream(KIND_ERROR);
                     end else begin
                        emitted = emitted + 24'd1;
                        add_result(leaf[7:0], KIND_SYMBOL);
                        walk_node = '0;
                        if (emitted >= limit_shadow) close_stream(KIND_END);
                     end
                  end
               end
               if (parse_state == PARSE_DATA && rq.last_flag) close_stream(KIND_END);
            end
         end
         default: ;
      endcase
      if (byte_results.size() > 0) begin
         r = byte_results.pop_back();
         r.run_end = 1'b1;
         byte_results.push_back(r);
      end
      foreach (byte_results[k]) awaited.push_back(byte_results[k]);
   endfunction

   // stream construction
   function automatic void set_slot(input int slot, input logic [15:0] link);
      tree_image[slot / 2][16 * (slot % 2) +: 16] = link;
   endfunction

   function automatic void build_tree(input int nodes, input int end_pct);
      int          open_slots[$];
      int          k;
      int          pick;
      logic [15:0] value;
      for (k = 0; k < nodes; k++) tree_image[k] = '0;
      open_slots.push_back(0);
      open_slots.push_back(1);
      for (k = 1; k < nodes; k++) begin
         pick = $urandom_range(open_slots.size() - 1);
         set_slot(open_slots[pick], 16'(k));
         open_slots.delete(pick);
         open_slots.push_back(2 * k);
         open_slots.push_back(2 * k + 1);
      end
      foreach (open_slots[j]) begin
         value = ($urandom_range(99) < end_pct) ? END_VALUE : 16'($urandom_range(255));
         set_slot(open_slots[j], ~value);
      end
   endfunction

   function automatic void corrupt_tree(input int nodes);
      int slot;
      slot = $urandom_range(2 * nodes - 1);
      if ($urandom_range(1) == 1) set_slot(slot, 16'($urandom_range(nodes, 16'h7FFF)));
      else set_slot(slot, 16'($urandom_range(16'h8000, 16'hFEFE)));
   endfunction

   function automatic void append_request(input logic [7:0] data, input logic first_flag,
                                          input logic last_flag);
      stream_request_type rq;
      rq.data       = data;
      rq.first_flag = first_flag;
      rq.last_flag  = last_flag;
      pending_stream.push_back(rq);
   endfunction

   function automatic void mark_last();
      stream_request_type rq;
      rq = pending_stream.pop_back();
      rq.last_flag = 1'b1;
      pending_stream.push_back(rq);
   endfunction

   function automatic void queue_stream(input logic [15:0] count_word, input int nodes,
                                        input int data_len, input bit close_on_last);
      int k;
      pending_stream.delete();
      append_request(count_word[7:0], 1'b1, 1'b0);
      append_request(count_word[15:8], 1'b0, 1'b0);
      for (k = 0; k < 4 * nodes; k++)
         append_request(tree_image[k / 4][8 * (k % 4) +: 8], 1'b0, 1'b0);
      for (k = 0; k < data_len; k++) append_request(8'($urandom), 1'b0, 1'b0);
      if (close_on_last && pending_stream.size() > 0) mark_last();
   endfunction

   // driving
   task automatic send_request(input logic [7:0] data, input logic first_flag,
                               input logic last_flag);
      stream_request_type rq;
      int                 gap;
      rq.data       = data;
      rq.first_flag = first_flag;
      rq.last_flag  = last_flag;
      gap = 0;
      while ($urandom_range(99) < request_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first_flag;
      req_tlast  <= last_flag;
      do @(posedge clock); while (!req_tready);
      if (first_flag || parse_state != PARSE_DONE) live_requests++;
      decode_request(rq);
   endtask

   task automatic send_pending();
      foreach (pending_stream[k])
         send_request(pending_stream[k].data, pending_stream[k].first_flag,
                      pending_stream[k].last_flag);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_output_limit(input logic [LIMIT_WIDTH-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_shadow = value;
   endtask

   task automatic send_random_stream();
      int pick;
      int nodes;
      int cut;
      int k;
      pick  = $urandom_range(99);
      nodes = ($urandom_range(9) == 0) ? $urandom_range(3, 8) : $urandom_range(1, 2);
      build_tree(nodes, 15);
      if (pick < 8) begin
         queue_stream(16'($urandom_range(TREE_LIMIT, 65535)), 0, $urandom_range(2), 1'b0);
      end else if (pick < 14) begin
         queue_stream(16'h0000, 0, $urandom_range(1, 3), $urandom_range(1) == 1);
      end else begin
         if (pick < 26) corrupt_tree(nodes);
         queue_stream(16'(nodes), nodes, $urandom_range(1, 3), $urandom_range(9) != 0);
         // cut inside the header
         if (pick >= 86) begin
            cut = $urandom_range(1, 4 * nodes + 1);
            while (pending_stream.size() > cut) void'(pending_stream.pop_back());
            mark_last();
         end
      end
      if (pick >= 96) begin
         for (k = 0; k < $urandom_range(1, 4); k++)
            append_request(8'($urandom), $urandom_range(7) == 0, $urandom_range(1) == 1);
      end
      send_pending();
   endtask

   // tests
   task automatic test_stream_headers();
      send_request(8'h00, 1'b0, 1'b0);  // no start flag needed after reset
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b0);  // empty tree
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1);
      send_request(8'hA5, 1'b1, 1'b1);  // truncated count
      send_request(8'h01, 1'b1, 1'b0);  // count equal to the tree size, one past the largest
      send_request(8'h01, 1'b0, 1'b0);
      send_request(8'h3C, 1'b0, 1'b1);  // ignored until restart
   endtask

   task automatic test_symbol_run();
      tree_image[0] = {~16'h00FF, ~16'h0000};
      queue_stream(16'd1, 1, 0, 1'b0);
      append_request(8'hF0, 1'b0, 1'b0);
      append_request(8'hFF, 1'b0, 1'b1);
      send_pending();
   endtask

   task automatic test_bad_leaf();
      tree_image[0] = {16'h0001, 16'h8000};
      queue_stream(16'd1, 1, 0, 1'b0);
      append_request(8'h00, 1'b0, 1'b0);
      send_pending();
   endtask

   task automatic test_output_limit();
      write_output_limit('0);
      build_tree(1, 0);
      queue_stream(16'd1, 1, 1, 1'b1);
      send_pending();
      write_output_limit(24'd1);
      build_tree(1, 0);
      queue_stream(16'd1, 1, 1, 1'b1);
      send_pending();
      write_output_limit(24'd3);
      build_tree(1, 0);
      queue_stream(16'd1, 1, 1, 1'b1);
      send_pending();
      write_output_limit(LIMIT_RESET);
      build_tree(1, 0);
      queue_stream(16'd1, 1, 1, 1'b0);
      send_pending();
      // lowered below what the open stream already emitted
      write_output_limit(24'd1);
      pending_stream.delete();
      append_request(8'($urandom), 1'b0, 1'b1);
      send_pending();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [LIMIT_WIDTH-1:0] limit,
                                      input int request_budget);
      int stop_at;
      write_output_limit(limit);
      request_idle_pct   = idle_pct;
      response_stall_pct = stall_pct;
      stop_at = live_requests + request_budget;
      while (live_requests < stop_at) send_random_stream();
   endtask

   task automatic test_backpressure();
      write_output_limit(LIMIT_RESET);
      request_idle_pct   = 0;
      response_stall_pct = 0;
      hold_off = 400;
      build_tree(2, 0);
      queue_stream(16'd2, 2, 4, 1'b1);
      send_pending();
      drain_results();
   endtask

   task automatic test_pause();
      int k;
      request_idle_pct   = 37;
      response_stall_pct = 37;
      build_tree(2, 10);
      queue_stream(16'd2, 2, 3, 1'b1);
      for (k = 0; k < pending_stream.size(); k++) begin
         if (k == 11) drain_results();
         send_request(pending_stream[k].data, pending_stream[k].first_flag,
                      pending_stream[k].last_flag);
      end
   endtask

   task automatic test_largest_tree();
      request_idle_pct   = 0;
      response_stall_pct = 37;
      build_tree(256, 5);
      queue_stream(16'd256, 256, 0, 1'b0);
      // count at the largest tree, cut short in the node list
      while (pending_stream.size() > 10) void'(pending_stream.pop_back());
      mark_last();
      send_pending();
   endtask

   always @(posedge clock) begin : response_side
      decode_result_type want;
      logic [7:0]        got_symbol;
      logic [23:0]       got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_symbol = rsp_tdata[7:0];
         got_count  = rsp_tdata[31:8];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected result sym %h kind %0d count %0d end %b",
                        got_symbol, rsp_tuser, got_count, rsp_tlast);
         end else begin
            want = awaited.pop_front();
            if (want.symbol !== got_symbol || want.kind !== rsp_tuser ||
                want.decoded_count !== got_count || want.run_end !== rsp_tlast) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"tb: mismatch, expected sym %h kind %0d count %0d end %b,",
                            " got sym %h kind %0d count %0d end %b"},
                           want.symbol, want.kind, want.decoded_count, want.run_end,
                           got_symbol, rsp_tuser, got_count, rsp_tlast);
            end
         end
      end
      if (hold_off > 0) begin
         hold_off    = hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= response_stall_pct);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_stream_headers();
      test_symbol_run();
      test_bad_leaf();
      test_output_limit();
      test_random_traffic(0, 0, LIMIT_RESET, 3);
      test_random_traffic(77, 0, 24'($urandom_range(2, 12)), 3);
      test_random_traffic(0, 77, LIMIT_RESET, 3);
      test_random_traffic(37, 37, 24'($urandom_range(13, 40)), 3);
      test_backpressure();
      test_pause();
      test_largest_tree();
      drain_results();
      if (mismatches == 0 && awaited.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
src/htsd_pkg.sv
src/htsd_ram.sv
src/htsd_ctrl.sv
src/htsd_datapath.sv
src/huffman_tree_stream_decoder_core.sv
sim/tb.sv
